// ===== src/drklr_pkg.sv =====
// Package for the dual-role key and layer remapper.
// Holds key codes, widths, item/result structs and register indexes.
// No dependencies.
package drklr_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned TYPE_W     = 5;
  localparam int unsigned CODE_W     = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned RUN_MAX    = 3;
  localparam int unsigned RUN_W      = 2;
  localparam int unsigned CMP_W      = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;

  localparam logic [TYPE_W-1:0] EV_KEY    = 5'd1;
  localparam logic [CODE_W-1:0] KC_ESC    = 10'd1;
  localparam logic [CODE_W-1:0] KC_RETURN = 10'd28;
  localparam logic [CODE_W-1:0] KC_LCTRL  = 10'd29;
  localparam logic [CODE_W-1:0] KC_D      = 10'd32;
  localparam logic [CODE_W-1:0] KC_F      = 10'd33;
  localparam logic [CODE_W-1:0] KC_LSHIFT = 10'd42;
  localparam logic [CODE_W-1:0] KC_M      = 10'd50;
  localparam logic [CODE_W-1:0] KC_LALT   = 10'd56;
  localparam logic [CODE_W-1:0] KC_CAPS   = 10'd58;
  localparam logic [CODE_W-1:0] KC_RCTRL  = 10'd97;
  localparam logic [CODE_W-1:0] KC_SYSREQ = 10'd99;
  localparam logic [CODE_W-1:0] KC_RALT   = 10'd100;
  localparam logic [CODE_W-1:0] KC_LMETA  = 10'd125;
  localparam logic [CODE_W-1:0] KC_RMETA  = 10'd126;

  localparam logic signed [VALUE_W-1:0] VAL_RELEASE = 32'sd0;
  localparam logic signed [VALUE_W-1:0] VAL_PRESS   = 32'sd1;

  typedef enum logic [0:0] {
    CFG_TAP_TIMEOUT = 1'b0,
    CFG_KBD_KIND    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                      command;
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;
  } item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         ev_type;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } ev_t;

  typedef struct packed {
    logic [RUN_W-1:0]     count;
    ev_t [RUN_MAX-1:0]    res;
  } run_t;

  typedef struct packed {
    logic                  layer;
    logic                  other;
    logic [TIMER_BITS-1:0] ms;
  } hold_t;

endpackage

// ===== src/drklr_if.sv =====
// Valid/ready channel interfaces for the remapper input and output.
// Depends on drklr_pkg for field widths.
interface drklr_in_if import drklr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;

  modport source (output valid, command, event_type, event_code, event_value, input ready);
  modport sink   (input valid, command, event_type, event_code, event_value, output ready);
endinterface

interface drklr_out_if import drklr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         out_type;
  logic [CODE_W-1:0]         out_code;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last_of_run;

  modport source (output valid, out_type, out_code, out_value, last_of_run, input ready);
  modport sink   (input valid, out_type, out_code, out_value, last_of_run, output ready);
endinterface

// ===== src/drklr_decode.sv =====
// Combinational decode of one item into up to three result events
// and the next hold/layer state. Depends on drklr_pkg.
module drklr_decode import drklr_pkg::*; (
  input  item_t             item_i,
  input  hold_t             hold_i,
  input  logic [TMO_W-1:0]  tap_timeout_i,
  input  logic              mac_i,
  output run_t              run_o,
  output hold_t             hold_o
);

  function automatic logic [CODE_W-1:0] layer_code(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = c;
    unique case (c)
      10'd16:  r = 10'd2;
      10'd17:  r = 10'd3;
      10'd18:  r = 10'd4;
      10'd19:  r = 10'd5;
      10'd20:  r = 10'd6;
      10'd21:  r = 10'd7;
      10'd22:  r = 10'd8;
      10'd23:  r = 10'd9;
      10'd24:  r = 10'd10;
      10'd25:  r = 10'd11;
      10'd30:  r = 10'd179;
      10'd31:  r = 10'd180;
      10'd32:  r = 10'd26;
      10'd33:  r = 10'd27;
      10'd34:  r = 10'd41;
      10'd35:  r = 10'd105;
      10'd36:  r = 10'd108;
      10'd37:  r = 10'd103;
      10'd38:  r = 10'd106;
      10'd39:  r = 10'd13;
      10'd40:  r = 10'd43;
      10'd44:  r = 10'd26;
      10'd45:  r = 10'd27;
      10'd46:  r = 10'd12;
      10'd47:  r = 10'd78;
      10'd50:  r = 10'd12;
      default: r = c;
    endcase
    return r;
  endfunction

  logic                      tap_ok;
  logic                      wrap;
  logic [CODE_W-1:0]         tap_code;
  logic [CODE_W-1:0]         ctrl_code;
  logic signed [VALUE_W-1:0] val;
  logic [CODE_W-1:0]         code;

  assign val  = item_i.event_value;
  assign code = item_i.event_code;
  assign wrap = (code == KC_M) || (code == KC_D) || (code == KC_F);
  // tap window: counter strictly below timeout and no other key pressed
  assign tap_ok = !hold_i.other &&
                  (CMP_W'(hold_i.ms) < CMP_W'(tap_timeout_i));
  assign tap_code  = (code == KC_CAPS) ? KC_ESC : KC_RETURN;
  assign ctrl_code = (code == KC_CAPS) ? KC_LCTRL : KC_RCTRL;

  always_comb begin
    hold_o = hold_i;
    run_o.count = '0;
    for (int i = 0; i < RUN_MAX; i++) begin
      run_o.res[i] = '{ev_type: item_i.event_type, code: code, value: val};
    end

    if (item_i.command) begin
      if (hold_i.ms != '1) begin
        hold_o.ms = hold_i.ms + 1'b1;
      end
    end else if (item_i.event_type != EV_KEY) begin
      run_o.count = RUN_W'(1);
    end else begin
      unique case (code)
        KC_RMETA: begin
          hold_o.layer = (val != VAL_RELEASE);
        end
        KC_RALT: begin
          if (!mac_i) begin
            hold_o.layer = (val != VAL_RELEASE);
          end else begin
            run_o.count = RUN_W'(1);
          end
        end
        KC_LALT: begin
          run_o.count = RUN_W'(1);
          run_o.res[0].code = mac_i ? code : KC_LMETA;
        end
        KC_LMETA: begin
          run_o.count = RUN_W'(1);
          run_o.res[0].code = mac_i ? code : KC_LALT;
        end
        KC_SYSREQ: begin
          run_o.count = RUN_W'(1);
          run_o.res[0].code = mac_i ? code : KC_RALT;
        end
        KC_CAPS, KC_RETURN: begin
          run_o.count = RUN_W'(1);
          run_o.res[0].code = ctrl_code;
          if (val == VAL_PRESS) begin
            hold_o.ms    = '0;
            hold_o.other = 1'b0;
          end else if (val == VAL_RELEASE && tap_ok) begin
            run_o.count  = RUN_W'(3);
            run_o.res[1] = '{ev_type: EV_KEY, code: tap_code, value: VAL_PRESS};
            run_o.res[2] = '{ev_type: EV_KEY, code: tap_code, value: VAL_RELEASE};
          end
        end
        default: begin
          hold_o.other = 1'b1;
          run_o.count  = RUN_W'(1);
          if (hold_i.layer) begin
            if (wrap) begin
              run_o.count  = RUN_W'(3);
              run_o.res[0] = '{ev_type: EV_KEY, code: KC_LSHIFT, value: VAL_PRESS};
              run_o.res[1].code = layer_code(code);
              run_o.res[2] = '{ev_type: EV_KEY, code: KC_LSHIFT, value: VAL_RELEASE};
            end else begin
              run_o.res[0].code = layer_code(code);
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== src/drklr_emit.sv =====
// Result register: holds the run of up to three events for one item and
// hands them out one per transfer. Depends on drklr_pkg and drklr_out_if.
module drklr_emit import drklr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  run_t         run_i,
  output logic         free_o,
  drklr_out_if.source  out_ch
);

  logic [RUN_W-1:0]  cnt_q, cnt_d;
  logic [RUN_W-1:0]  idx_q, idx_d;
  ev_t [RUN_MAX-1:0] slot_q;
  ev_t               cur;
  logic              fire;
  logic              last;

  assign fire   = out_ch.valid && out_ch.ready;
  assign last   = (idx_q == cnt_q - 1'b1);
  // free for a new run when empty or as the final event of the current one goes out
  assign free_o = (cnt_q == '0) || (fire && last);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = run_i.count;
      idx_d = '0;
    end else if (fire) begin
      if (last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= run_i.res;
    end
  end

  always_comb begin
    unique case (idx_q)
      2'd0:    cur = slot_q[0];
      2'd1:    cur = slot_q[1];
      default: cur = slot_q[2];
    endcase
  end

  assign out_ch.valid       = (cnt_q != '0);
  assign out_ch.out_type    = cur.ev_type;
  assign out_ch.out_code    = cur.code;
  assign out_ch.out_value   = cur.value;
  assign out_ch.last_of_run = last;

endmodule

// ===== src/dual_role_key_layer_remapper.sv =====
// Dual-role key and layer remapper, top level.
// Path to first result: input register, then result register. Throughput:
// one input item per cycle unless an item with results waits for the result
// register; an item with k results holds it for k output transfers (k <= 3).
// Reset: layer and other-key flags clear, hold timer saturates, timeout 200,
// standard keyboard; no clearing pass.
module dual_role_key_layer_remapper import drklr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  drklr_in_if.sink          in_ch,
  drklr_out_if.source       out_ch,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [TMO_W-1:0]  cfg_data_i
);

  // configuration registers
  logic [TMO_W-1:0] tap_timeout_q;
  logic             mac_q;

  // input register
  logic  in_valid_q;
  item_t item_q;

  // hold / layer state
  hold_t hold_q, hold_d;

  run_t  run;
  logic  emit_free;
  logic  advance;
  logic  load;
  logic  in_fire;

  // Item leaves the input register when its results fit in the result
  // register. Ticks and layer-key events produce nothing and never wait.
  assign advance      = in_valid_q && ((run.count == '0) || emit_free);
  assign load         = advance && (run.count != '0);
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_timeout_q <= TMO_W'(200);
      mac_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TAP_TIMEOUT: tap_timeout_q <= cfg_data_i;
        CFG_KBD_KIND:    mac_q         <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{command:     in_ch.command,
                  event_type:  in_ch.event_type,
                  event_code:  in_ch.event_code,
                  event_value: in_ch.event_value};
    end
  end

  // state commits in item order, as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '{layer: 1'b0, other: 1'b0, ms: '1};
    end else if (advance) begin
      hold_q <= hold_d;
    end
  end

  drklr_decode u_decode (
    .item_i        (item_q),
    .hold_i        (hold_q),
    .tap_timeout_i (tap_timeout_q),
    .mac_i         (mac_q),
    .run_o         (run),
    .hold_o        (hold_d)
  );

  drklr_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .run_i  (run),
    .free_o (emit_free),
    .out_ch (out_ch)
  );

endmodule

// ===== src/drklr_checker.sv =====
// Port-level checker for the remapper output channel, bound to the top.
// Depends on drklr_pkg and dual_role_key_layer_remapper.
module drklr_checker import drklr_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [TYPE_W-1:0]         out_type_i,
  input logic [CODE_W-1:0]         out_code_i,
  input logic signed [VALUE_W-1:0] out_value_i,
  input logic                      last_of_run_i
);

  // output stays quiet on the first edge after reset
  a_idle_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_type_i) && $stable(out_code_i) &&
      $stable(out_value_i) && $stable(last_of_run_i))
    else $error("stalled result changed");

  // a run is delivered without gaps
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=> out_valid_i)
    else $error("gap inside a run");

  // a shift press that opens a run is followed by the key event
  a_shift_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i && out_type_i == EV_KEY &&
    out_code_i == KC_LSHIFT && out_value_i == VAL_PRESS |=>
      out_valid_i && out_type_i == EV_KEY)
    else $error("shift wrap not followed by key event");

endmodule

bind dual_role_key_layer_remapper drklr_checker u_drklr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_type_i    (out_ch.out_type),
  .out_code_i    (out_ch.out_code),
  .out_value_i   (out_ch.out_value),
  .last_of_run_i (out_ch.last_of_run)
);
